/* src/omd_pkg.sv */
// omd_pkg: shared types, constants and helpers of the osc message deframer
// no dependencies; every other file of the block but omd_if imports it
`default_nettype none

package omd_pkg;

    // sizing
    localparam int MAX_ARGS      = 64;
    localparam int OFFSET_BITS   = 16;
    localparam int TAG_ADDR_BITS = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam int CNT_BITS      = $clog2(MAX_ARGS + 1);

    localparam logic [CNT_BITS-1:0] MAX_ARGS_CNT = CNT_BITS'(MAX_ARGS);

    // characters of the osc syntax
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_I   = 8'h69;
    localparam logic [7:0] CHAR_F   = 8'h66;
    localparam logic [7:0] CHAR_S   = 8'h73;

    typedef enum logic [3:0] {
        PH_ADDR  = 4'b0001,
        PH_COMMA = 4'b0010,
        PH_TAGS  = 4'b0100,
        PH_ARGS  = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        BC_ADDR       = 3'd0,
        BC_ADDR_PAD   = 3'd1,
        BC_COMMA      = 3'd2,
        BC_TAG        = 3'd3,
        BC_TAG_PAD    = 3'd4,
        BC_NUMERIC    = 3'd5,
        BC_STRING     = 3'd6,
        BC_STRING_PAD = 3'd7
    } byte_class_t;

    typedef enum logic [1:0] {
        AT_INT     = 2'd0,
        AT_FLOAT   = 2'd1,
        AT_STRING  = 2'd2,
        AT_UNKNOWN = 2'd3
    } arg_type_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_UNKNOWN   = 3'd1,
        ERR_TOO_MANY  = 3'd2,
        ERR_TRUNCATED = 3'd3,
        ERR_EXCESS    = 3'd4
    } err_code_t;

    // one known argument; gap marks unknown tags skipped right before it
    typedef struct packed {
        logic                     gap;
        logic [TAG_ADDR_BITS-1:0] idx;
        arg_type_t                typ;
    } tag_entry_t;

    typedef struct packed {
        logic                     en;
        logic [TAG_ADDR_BITS-1:0] addr;
        tag_entry_t               data;
    } tag_wr_t;

    typedef struct packed {
        byte_class_t cls;
        logic [5:0]  idx;
        arg_type_t   typ;
        logic [15:0] off;
        logic [31:0] val;
        logic        valid;
        err_code_t   err;
        logic        done;
    } result_t;

    function automatic arg_type_t tag_type(input logic [7:0] b);
        arg_type_t t;
        if (b == CHAR_I) t = AT_INT;
        else if (b == CHAR_F) t = AT_FLOAT;
        else if (b == CHAR_S) t = AT_STRING;
        else t = AT_UNKNOWN;
        return t;
    endfunction

endpackage

`default_nettype wire

/* src/omd_if.sv */
// omd_byte_if / omd_result_if: valid-ready channels of the deframer
// depends on nothing but the payload widths fixed by the byte protocol
`default_nettype none

interface omd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface omd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_class;
    logic [5:0]  arg_index;
    logic [1:0]  arg_type;
    logic [15:0] arg_offset;
    logic [31:0] arg_value;
    logic        value_valid;
    logic [2:0]  error_code;
    logic        packet_done;

    modport source (output valid, output byte_class, output arg_index, output arg_type,
                    output arg_offset, output arg_value, output value_valid,
                    output error_code, output packet_done, input ready);
    modport sink (input valid, input byte_class, input arg_index, input arg_type,
                  input arg_offset, input arg_value, input value_valid,
                  input error_code, input packet_done, output ready);
endinterface

`default_nettype wire

/* src/omd_tag_ram.sv */
// omd_tag_ram: store of known arguments, one write and one registered read port
// depends on omd_pkg
`default_nettype none

module omd_tag_ram (
    input  wire logic                             clk,
    input  wire omd_pkg::tag_wr_t                 wr,
    input  wire logic [omd_pkg::TAG_ADDR_BITS-1:0] rd_addr,
    output omd_pkg::tag_entry_t                   rd_data
);
    import omd_pkg::*;

    tag_entry_t mem [MAX_ARGS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* src/omd_parser.sv */
// omd_parser: per-byte state update of the deframer, reads and fills the tag ram
// depends on omd_pkg
`default_nettype none

module omd_parser (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire logic [7:0]                        data_byte,
    input  wire logic                              end_of_packet,
    input  wire omd_pkg::tag_entry_t               rd_data,
    output logic [omd_pkg::TAG_ADDR_BITS-1:0]      rd_addr,
    output omd_pkg::tag_wr_t                       tag_wr,
    output omd_pkg::result_t                       res
);
    import omd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             align_reg, align_next;
    logic                   ended_reg, ended_next;
    logic [CNT_BITS-1:0]    tag_count_reg, tag_count_next;
    logic [CNT_BITS-1:0]    known_count_reg, known_count_next;
    logic [CNT_BITS-1:0]    next_exp_reg, next_exp_next;
    logic [CNT_BITS-1:0]    kp_reg, kp_next;
    logic [CNT_BITS-1:0]    cur_arg_reg, cur_arg_next;
    logic [OFFSET_BITS-1:0] region_reg, region_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [31:0]            shift_reg, shift_next;
    logic                   active_reg, active_next;

    // effective per-argument state once a new argument has been opened
    logic                   active_e;
    logic                   ended_e;
    logic [1:0]             align_e;
    logic [31:0]            shift_e;
    logic [OFFSET_BITS-1:0] start_e;
    logic                   skip_e;
    logic                   ended2;
    logic [1:0]             align2;
    logic [31:0]            shift2;
    logic                   nul;
    logic                   complete;
    arg_type_t              ttype;

    assign rd_addr = kp_next[TAG_ADDR_BITS-1:0];

    always_comb
    begin
        phase_next       = phase_reg;
        align_next       = align_reg;
        ended_next       = ended_reg;
        tag_count_next   = tag_count_reg;
        known_count_next = known_count_reg;
        next_exp_next    = next_exp_reg;
        kp_next          = kp_reg;
        cur_arg_next     = cur_arg_reg;
        region_next      = region_reg;
        start_next       = start_reg;
        shift_next       = shift_reg;
        active_next      = active_reg;

        active_e = active_reg;
        ended_e  = ended_reg;
        align_e  = align_reg;
        shift_e  = shift_reg;
        start_e  = start_reg;
        skip_e   = 1'b0;
        ended2   = 1'b0;
        align2   = 2'd0;
        shift2   = '0;
        complete = 1'b0;
        nul      = (data_byte == CHAR_NUL);
        ttype    = tag_type(data_byte);

        tag_wr   = '0;
        res      = '0;
        res.cls  = BC_ADDR;
        res.typ  = AT_INT;
        res.err  = ERR_NONE;
        res.done = end_of_packet;

        if (load)
        begin
            if (phase_reg != PH_ARGS)
            begin
                // header strings: address, comma, tags
                unique case (phase_reg)
                    PH_ADDR:
                    begin
                        res.cls = (!ended_reg && !nul) ? BC_ADDR : BC_ADDR_PAD;
                    end
                    PH_COMMA:
                    begin
                        res.cls    = nul ? BC_TAG_PAD : BC_COMMA;
                        phase_next = PH_TAGS;
                    end
                    PH_TAGS:
                    begin
                        if (ended_reg || nul)
                        begin
                            res.cls = BC_TAG_PAD;
                        end
                        else
                        begin
                            res.cls = BC_TAG;
                            res.idx = 6'(tag_count_reg);
                            res.typ = ttype;
                            if (tag_count_reg < MAX_ARGS_CNT)
                            begin
                                tag_count_next = tag_count_reg + CNT_BITS'(1);
                                // only known tags go into the store
                                if (ttype != AT_UNKNOWN)
                                begin
                                    tag_wr.en       = 1'b1;
                                    tag_wr.addr     = known_count_reg[TAG_ADDR_BITS-1:0];
                                    tag_wr.data.gap = (tag_count_reg != next_exp_reg);
                                    tag_wr.data.idx = tag_count_reg[TAG_ADDR_BITS-1:0];
                                    tag_wr.data.typ = ttype;
                                    known_count_next = known_count_reg + CNT_BITS'(1);
                                    next_exp_next    = tag_count_reg + CNT_BITS'(1);
                                end
                            end
                            else
                            begin
                                res.err = ERR_TOO_MANY;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase

                ended2     = ended_reg | nul;
                align2     = align_reg + 2'd1;
                align_next = align2;
                ended_next = ended2;
                if (ended2 && (align2 == 2'd0))
                begin
                    ended_next = 1'b0;
                    if (phase_reg == PH_ADDR)
                    begin
                        phase_next = PH_COMMA;
                    end
                    else
                    begin
                        phase_next   = PH_ARGS;
                        cur_arg_next = '0;
                        region_next  = '0;
                        start_next   = '0;
                        active_next  = 1'b0;
                        kp_next      = '0;
                    end
                end
            end
            else
            begin
                // argument region; rd_data holds the entry at kp_reg
                if (!active_reg && (kp_reg < known_count_reg))
                begin
                    active_e = 1'b1;
                    start_e  = region_reg;
                    align_e  = 2'd0;
                    shift_e  = '0;
                    ended_e  = 1'b0;
                    skip_e   = rd_data.gap;
                end

                if (!active_e)
                begin
                    res.cls      = BC_STRING_PAD;
                    res.idx      = 6'(tag_count_reg);
                    res.typ      = AT_UNKNOWN;
                    res.off      = 16'(region_reg);
                    res.err      = ERR_EXCESS;
                    cur_arg_next = tag_count_reg;
                end
                else
                begin
                    res.idx     = 6'(rd_data.idx);
                    res.typ     = rd_data.typ;
                    res.off     = 16'(start_e);
                    res.err     = skip_e ? ERR_UNKNOWN : ERR_NONE;
                    start_next  = start_e;
                    active_next = 1'b1;
                    align2      = align_e + 2'd1;
                    align_next  = align2;
                    if (rd_data.typ == AT_STRING)
                    begin
                        res.cls    = (!ended_e && !nul) ? BC_STRING : BC_STRING_PAD;
                        ended2     = ended_e | nul;
                        ended_next = ended2;
                        shift_next = shift_e;
                        if (ended2 && (align2 == 2'd0))
                        begin
                            ended_next   = 1'b0;
                            active_next  = 1'b0;
                            kp_next      = kp_reg + CNT_BITS'(1);
                            cur_arg_next = CNT_BITS'(rd_data.idx) + CNT_BITS'(1);
                        end
                    end
                    else
                    begin
                        res.cls    = BC_NUMERIC;
                        shift2     = {shift_e[23:0], data_byte};
                        res.val    = shift2;
                        shift_next = shift2;
                        ended_next = ended_e;
                        if (align2 == 2'd0)
                        begin
                            res.valid    = 1'b1;
                            active_next  = 1'b0;
                            kp_next      = kp_reg + CNT_BITS'(1);
                            cur_arg_next = CNT_BITS'(rd_data.idx) + CNT_BITS'(1);
                        end
                    end
                end
                region_next = region_reg + OFFSET_BITS'(1);
            end

            if (end_of_packet)
            begin
                complete = (phase_next == PH_ARGS) && !active_next &&
                           (kp_next >= known_count_next);
                // trailing unknown tags after the last known argument
                if (complete && (cur_arg_next < tag_count_next) && (res.err == ERR_NONE))
                begin
                    res.err = ERR_UNKNOWN;
                end
                if (!complete)
                begin
                    res.err = ERR_TRUNCATED;
                end
                phase_next       = PH_ADDR;
                align_next       = '0;
                ended_next       = 1'b0;
                tag_count_next   = '0;
                known_count_next = '0;
                next_exp_next    = '0;
                kp_next          = '0;
                cur_arg_next     = '0;
                region_next      = '0;
                start_next       = '0;
                shift_next       = '0;
                active_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_ADDR;
            align_reg       <= '0;
            ended_reg       <= 1'b0;
            tag_count_reg   <= '0;
            known_count_reg <= '0;
            next_exp_reg    <= '0;
            kp_reg          <= '0;
            cur_arg_reg     <= '0;
            region_reg      <= '0;
            start_reg       <= '0;
            shift_reg       <= '0;
            active_reg      <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            align_reg       <= align_next;
            ended_reg       <= ended_next;
            tag_count_reg   <= tag_count_next;
            known_count_reg <= known_count_next;
            next_exp_reg    <= next_exp_next;
            kp_reg          <= kp_next;
            cur_arg_reg     <= cur_arg_next;
            region_reg      <= region_next;
            start_reg       <= start_next;
            shift_reg       <= shift_next;
            active_reg      <= active_next;
        end
    end

endmodule

`default_nettype wire

/* src/omd_result_reg.sv */
// omd_result_reg: output register of the deframer, frees the input side while empty or being read
// depends on omd_pkg and omd_result_if
`default_nettype none

module omd_result_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire omd_pkg::result_t res,
    output logic                  space,
    omd_result_if.source          result
);
    import omd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign space = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && space)
        begin
            data_reg <= res;
        end
    end

    assign result.valid       = valid_reg;
    assign result.byte_class  = data_reg.cls;
    assign result.arg_index   = data_reg.idx;
    assign result.arg_type    = data_reg.typ;
    assign result.arg_offset  = data_reg.off;
    assign result.arg_value   = data_reg.val;
    assign result.value_valid = data_reg.valid;
    assign result.error_code  = data_reg.err;
    assign result.packet_done = data_reg.done;

endmodule

`default_nettype wire

/* src/osc_message_deframer.sv */
// throughput: one byte per cycle while the sink does not stall the output register,
// sustained across tag, argument and packet bounds; each result is registered
// the tag ram read is prefetched at the next argument pointer
// reset: rst_n asynchronous, active low; returns to the address phase, counters cleared
// the tag ram is not cleared; only entries written in the current packet are read
`default_nettype none

module osc_message_deframer (
    input  wire logic     clk,
    input  wire logic     rst_n,
    omd_byte_if.sink      msg,
    omd_result_if.source  result
);
    import omd_pkg::*;

    logic                     space;
    logic                     load;
    tag_wr_t                  tag_wr;
    tag_entry_t               rd_data;
    logic [TAG_ADDR_BITS-1:0] rd_addr;
    result_t                  res;

    // a request is taken whenever the output register is free or being emptied
    assign msg.ready = space;
    assign load      = msg.valid && space;

    // only known tags are stored, packed in order, each with its original index
    // and a flag for unknown tags skipped before it; the args phase walks them
    // with a single pointer, so a run of unknown tags is skipped without a stall.
    // the last tag write is always followed by at least the terminating null,
    // so the prefetched read never races a write of the same entry
    omd_tag_ram u_tag_ram (
        .clk     (clk),
        .wr      (tag_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // byte classification, value assembly and error detection
    omd_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .data_byte     (msg.data_byte),
        .end_of_packet (msg.end_of_packet),
        .rd_data       (rd_data),
        .rd_addr       (rd_addr),
        .tag_wr        (tag_wr),
        .res           (res)
    );

    // registered result; while the sink stalls a full register, no byte is taken
    omd_result_reg u_result_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .res    (res),
        .space  (space),
        .result (result)
    );

endmodule

`default_nettype wire

/* src/omd_checker.sv */
// omd_checker: port-level assertions of the deframer, bound to the top level
// depends on omd_pkg and osc_message_deframer
`default_nettype none

module omd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  byte_class,
    input wire logic [1:0]  arg_type,
    input wire logic        value_valid,
    input wire logic [2:0]  error_code
);
    import omd_pkg::*;

    // a held result keeps its byte class and error code
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_class) && $stable(error_code))
        else $error("held result changed");

    // no new request while the result register is full and stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken over a stalled result");

    // a completed value only ever comes from a numeric argument byte
    a_value_numeric: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_valid |-> byte_class == BC_NUMERIC)
        else $error("value_valid outside a numeric argument");

    // excess bytes are string pad of unknown type
    a_excess_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_EXCESS |->
            byte_class == BC_STRING_PAD && arg_type == AT_UNKNOWN)
        else $error("malformed excess byte result");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> error_code <= ERR_EXCESS)
        else $error("error code out of range");

endmodule

bind osc_message_deframer omd_checker u_omd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (msg.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .byte_class  (result.byte_class),
    .arg_type    (result.arg_type),
    .value_valid (result.value_valid),
    .error_code  (result.error_code)
);

`default_nettype wire
